FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the key hash bucket index RTL.
// Depends on nothing; included by modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define KHBI_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define KHBI_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/khbi_pkg.sv
// Shared types and constants for the key hash bucket index block.
// No dependencies; used by khbi_alu, khbi_mod and key_hash_bucket_index.
package khbi_pkg;

    localparam int unsigned HASH_W  = 32;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned CNT_W   = 17;
    localparam int unsigned IDX_W   = 16;

    localparam logic [CNT_W-1:0] BUCKET_COUNT_RESET = 17'd1024;
    localparam logic [CNT_W-1:0] BUCKET_COUNT_MAX   = 17'd65536;

    // one-at-a-time shift amounts
    localparam int unsigned MIX_SHL = 10;
    localparam int unsigned MIX_SHR = 6;
    localparam int unsigned FIN_SHL_A = 3;
    localparam int unsigned FIN_SHR   = 11;
    localparam int unsigned FIN_SHL_B = 15;

    typedef enum logic [2:0] {
        ALU_ADD_BYTE,
        ALU_ADD_SHL10,
        ALU_XOR_SHR6,
        ALU_ADD_SHL3,
        ALU_XOR_SHR11,
        ALU_ADD_SHL15
    } alu_op_t;

    typedef struct packed {
        logic              start;
        logic [HASH_W-1:0] dividend;
        logic [CNT_W-1:0]  divisor;
    } mod_ctrl_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [IDX_W-1:0] rem;
    } mod_stat_t;

endpackage

FILE: rtl/core/key_hash_bucket_index.sv
// Top level: one-at-a-time key hash with bucket index (hash mod bucket count).
// Depends on khbi_pkg, khbi_alu, khbi_mod and assert_macros.svh.
//
//  channel  | dir | handshake            | payload
//  ---------+-----+----------------------+------------------------------------------
//  s_axis   | in  | s_axis_tvalid/tready | tdata key_byte, tuser byte_present,
//           |     |                      | tlast last_byte
//  m_axis   | out | m_axis_tvalid/tready | tdata hash_value[31:0], bucket_index[47:32]
//  cfg      | in  | cfg_valid/cfg_ready  | cfg_data bucket_count (17 bits)
//
// Steps: a request without last_byte passes accept, add, shift-10 add and
//   shift-6 xor, or only accept and add when no byte is present; the shared hash
//   step unit does one operation per cycle.
// A request with last_byte adds 3 finalize steps, the bit-serial modulo unit and
//   the load of the output register; m_axis_tvalid rises as the block returns to
//   taking the next request.
// Reset: asynchronous, active low; clears running hash, state and output valid,
//   and sets bucket_count to 1024. No clearing pass.
// Stalls: the finished result sits in an output register; new requests are taken
//   while it waits, and only a next result waits for that register to drain.
// cfg_ready is always high; bucket_count 0 acts as 1, above 65536 as 65536.
`include "assert_macros.svh"

module key_hash_bucket_index
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] key_byte
    input  logic        s_axis_tuser,   // [0] byte_present
    input  logic        s_axis_tlast,   // last_byte

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // [31:0] hash_value, [47:32] bucket_index

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [16:0] cfg_data        // bucket_count
);

    typedef enum logic [8:0] {
        ST_IDLE    = 9'b000000001,
        ST_ADD     = 9'b000000010,
        ST_MIX_SHL = 9'b000000100,
        ST_MIX_XOR = 9'b000001000,
        ST_FIN_A   = 9'b000010000,
        ST_FIN_XOR = 9'b000100000,
        ST_FIN_B   = 9'b001000000,
        ST_MOD     = 9'b010000000,
        ST_DONE    = 9'b100000000
    } state_t;

    state_t                          state_reg, state_next;
    logic [khbi_pkg::HASH_W-1:0]     hash_reg, hash_next;
    logic [khbi_pkg::BYTE_W-1:0]     byte_reg;
    logic                            present_reg;
    logic                            last_reg;
    logic [khbi_pkg::CNT_W-1:0]      bucket_count_reg;
    logic [khbi_pkg::CNT_W-1:0]      buckets_eff;

    logic                            out_valid_reg;
    logic [khbi_pkg::HASH_W-1:0]     out_hash_reg;
    logic [khbi_pkg::IDX_W-1:0]      out_idx_reg;
    logic                            out_load;

    khbi_pkg::alu_op_t               alu_op;
    logic [khbi_pkg::HASH_W-1:0]     alu_res;
    khbi_pkg::mod_ctrl_t             mod_ctrl;
    khbi_pkg::mod_stat_t             mod_stat;

    logic                            in_acc;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;

    // clamp the configured count into 1..65536
    always_comb
    begin
        if (bucket_count_reg == '0)
            buckets_eff = khbi_pkg::CNT_W'(1);
        else if (bucket_count_reg > khbi_pkg::BUCKET_COUNT_MAX)
            buckets_eff = khbi_pkg::BUCKET_COUNT_MAX;
        else
            buckets_eff = bucket_count_reg;
    end

    khbi_alu u_alu
    (
        .op       (alu_op),
        .hash_in  (hash_reg),
        .byte_in  (byte_reg),
        .hash_out (alu_res)
    );

    khbi_mod u_mod
    (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (mod_ctrl),
        .stat  (mod_stat)
    );

    // output register frees up when empty or being taken this cycle
    assign out_load = (state_reg == ST_DONE) && (!out_valid_reg || m_axis_tready);

    always_comb
    begin
        state_next        = state_reg;
        hash_next         = hash_reg;
        alu_op            = khbi_pkg::ALU_ADD_BYTE;
        mod_ctrl.start    = 1'b0;
        mod_ctrl.dividend = alu_res;
        mod_ctrl.divisor  = buckets_eff;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                    state_next = ST_ADD;
            end
            ST_ADD:
            begin
                alu_op = khbi_pkg::ALU_ADD_BYTE;
                if (present_reg)
                begin
                    hash_next  = alu_res;
                    state_next = ST_MIX_SHL;
                end
                else if (last_reg)
                    state_next = ST_FIN_A;
                else
                    state_next = ST_IDLE;
            end
            ST_MIX_SHL:
            begin
                alu_op     = khbi_pkg::ALU_ADD_SHL10;
                hash_next  = alu_res;
                state_next = ST_MIX_XOR;
            end
            ST_MIX_XOR:
            begin
                alu_op     = khbi_pkg::ALU_XOR_SHR6;
                hash_next  = alu_res;
                state_next = last_reg ? ST_FIN_A : ST_IDLE;
            end
            ST_FIN_A:
            begin
                alu_op     = khbi_pkg::ALU_ADD_SHL3;
                hash_next  = alu_res;
                state_next = ST_FIN_XOR;
            end
            ST_FIN_XOR:
            begin
                alu_op     = khbi_pkg::ALU_XOR_SHR11;
                hash_next  = alu_res;
                state_next = ST_FIN_B;
            end
            ST_FIN_B:
            begin
                // finished hash goes to the modulo unit and the hash register at once
                alu_op         = khbi_pkg::ALU_ADD_SHL15;
                hash_next      = alu_res;
                mod_ctrl.start = 1'b1;
                state_next     = ST_MOD;
            end
            ST_MOD:
            begin
                if (mod_stat.done)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    hash_next  = '0;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            hash_reg         <= '0;
            bucket_count_reg <= khbi_pkg::BUCKET_COUNT_RESET;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            hash_reg  <= hash_next;
            if (cfg_valid && cfg_ready)
                bucket_count_reg <= cfg_data;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            byte_reg    <= s_axis_tdata;
            present_reg <= s_axis_tuser;
            last_reg    <= s_axis_tlast;
        end
        if (out_load)
        begin
            out_hash_reg <= hash_reg;
            out_idx_reg  <= mod_stat.rem;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_idx_reg, out_hash_reg};

    `KHBI_ASSERT_IMP(a_idle_mod_free, clk, rst_n, s_axis_tready, !mod_stat.busy,
        "modulo unit busy while taking requests")
    `KHBI_ASSERT_IMP(a_done_in_mod, clk, rst_n, mod_stat.done, state_reg == ST_MOD,
        "modulo finished outside its wait state")
    `KHBI_ASSERT_NXT(a_load_clears, clk, rst_n, out_load,
        (hash_reg == '0) && m_axis_tvalid, "running hash not cleared after result")

endmodule

FILE: rtl/core/khbi_alu.sv
// Shared hash step unit: one add, shift-add or shift-xor per cycle.
// Depends on khbi_pkg.
module khbi_alu
(
    input  khbi_pkg::alu_op_t                 op,
    input  logic [khbi_pkg::HASH_W-1:0]       hash_in,
    input  logic [khbi_pkg::BYTE_W-1:0]       byte_in,
    output logic [khbi_pkg::HASH_W-1:0]       hash_out
);

    always_comb
    begin
        unique case (op)
            khbi_pkg::ALU_ADD_BYTE:
                hash_out = hash_in + {{(khbi_pkg::HASH_W-khbi_pkg::BYTE_W){1'b0}}, byte_in};
            khbi_pkg::ALU_ADD_SHL10:
                hash_out = hash_in + (hash_in << khbi_pkg::MIX_SHL);
            khbi_pkg::ALU_XOR_SHR6:
                hash_out = hash_in ^ (hash_in >> khbi_pkg::MIX_SHR);
            khbi_pkg::ALU_ADD_SHL3:
                hash_out = hash_in + (hash_in << khbi_pkg::FIN_SHL_A);
            khbi_pkg::ALU_XOR_SHR11:
                hash_out = hash_in ^ (hash_in >> khbi_pkg::FIN_SHR);
            khbi_pkg::ALU_ADD_SHL15:
                hash_out = hash_in + (hash_in << khbi_pkg::FIN_SHL_B);
            default:
                hash_out = hash_in;
        endcase
    end

endmodule

FILE: rtl/core/khbi_mod.sv
// Bit-serial restoring modulo: 32-bit dividend by 17-bit divisor, one bit a cycle.
// Depends on khbi_pkg and assert_macros.svh.
`include "assert_macros.svh"

module khbi_mod
(
    input  logic                clk,
    input  logic                rst_n,
    input  khbi_pkg::mod_ctrl_t ctrl,
    output khbi_pkg::mod_stat_t stat
);

    localparam int unsigned STEP_W = $clog2(khbi_pkg::HASH_W);

    logic                          busy_reg, busy_next;
    logic [STEP_W-1:0]             cnt_reg, cnt_next;
    logic [khbi_pkg::HASH_W-1:0]   dvd_reg, dvd_next;
    logic [khbi_pkg::CNT_W-1:0]    div_reg, div_next;
    logic [khbi_pkg::IDX_W-1:0]    rem_reg, rem_next;
    logic [khbi_pkg::CNT_W-1:0]    shifted;
    logic                          last_step;

    assign shifted   = {rem_reg, dvd_reg[khbi_pkg::HASH_W-1]};
    assign last_step = busy_reg && (cnt_reg == STEP_W'(khbi_pkg::HASH_W - 1));

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        div_next  = div_reg;
        rem_next  = rem_reg;
        if (ctrl.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            dvd_next  = ctrl.dividend;
            div_next  = ctrl.divisor;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            dvd_next = {dvd_reg[khbi_pkg::HASH_W-2:0], 1'b0};
            cnt_next = cnt_reg + STEP_W'(1);
            // remainder stays below divisor <= 65536, so 16 bits hold it
            if (shifted >= div_reg)
                rem_next = khbi_pkg::IDX_W'(shifted - div_reg);
            else
                rem_next = shifted[khbi_pkg::IDX_W-1:0];
            if (last_step)
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        div_reg <= div_next;
        rem_reg <= rem_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = last_step;
    assign stat.rem  = rem_reg;

    `KHBI_ASSERT_IMP(a_start_idle, clk, rst_n, ctrl.start, !busy_reg, "modulo start while busy")
    `KHBI_ASSERT_IMP(a_rem_below, clk, rst_n, busy_reg && (cnt_reg != '0),
        ({1'b0, rem_reg} < div_reg), "partial remainder not below divisor")
    `KHBI_ASSERT_NXT(a_done_idle, clk, rst_n, last_step, !busy_reg, "modulo busy after last step")

endmodule
